// ----- rtl/mlsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_pkg
// Shared constants and a field-addition helper for secret recovery.
// ---------------------------------------------------------------------------
package mlsr_pkg;

   localparam int DATA_W         = 30;
   localparam int X_W            = 16;
   localparam int RADIX_W        = 6;
   localparam int DIGIT_W        = 6;
   localparam int CSR_W          = 5;
   localparam int MAX_SHARES_DEF = 16;
   localparam int FIFO_DEPTH_DEF = 2;

   localparam logic [DATA_W-1:0] PRIME    = 30'd1000000007;
   // Exponent for inversion by Fermat's little theorem; zero maps to zero.
   localparam logic [DATA_W-1:0] PRIME_M2 = 30'd1000000005;

   // Sum of two field elements, both below the prime.
   function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[DATA_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mlsr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_if
// Channel interfaces: share digits in, secrets out, threshold register.
// ---------------------------------------------------------------------------
interface mlsr_req_if;
   logic                            valid;
   logic                            ready;
   logic [mlsr_pkg::X_W-1:0]        share_x;
   logic [mlsr_pkg::RADIX_W-1:0]    radix;
   logic [mlsr_pkg::DIGIT_W-1:0]    digit;
   logic                            value_last;
   logic                            set_last;
   modport source (output valid, share_x, radix, digit, value_last, set_last,
                   input ready);
   modport sink   (input valid, share_x, radix, digit, value_last, set_last,
                   output ready);
endinterface

interface mlsr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mlsr_pkg::DATA_W-1:0]     secret;
   modport source (output valid, secret, input ready);
   modport sink   (input valid, secret, output ready);
endinterface

interface mlsr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mlsr_pkg::CSR_W-1:0]      data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/mlsr_modmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_modmul
// Interleaved modular multiplier, one multiplier bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module mlsr_modmul #(
   parameter int OPB_W = mlsr_pkg::DATA_W
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start_i,
   input  wire logic [mlsr_pkg::DATA_W-1:0] opa_i,
   input  wire logic [OPB_W-1:0]            opb_i,
   output      logic                        busy_o,
   output      logic                        done_o,
   output      logic [mlsr_pkg::DATA_W-1:0] result_o
);
   localparam int CW = (OPB_W > 1) ? $clog2(OPB_W) : 1;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [mlsr_pkg::DATA_W-1:0] a_ff, a_in;
   logic [OPB_W-1:0]            b_ff, b_in;
   logic [mlsr_pkg::DATA_W-1:0] r_ff, r_in;
   logic [mlsr_pkg::DATA_W-1:0] dbl;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      dbl     = mlsr_pkg::mod_add(r_ff, r_ff);
      if (busy_ff) begin
         r_in = b_ff[OPB_W-1] ? mlsr_pkg::mod_add(dbl, a_ff) : dbl;
         b_in = b_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start_i) begin
         busy_in = 1'b1;
         a_in    = opa_i;
         b_in    = opb_i;
         r_in    = '0;
         cnt_in  = CW'(OPB_W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
   end

   assign busy_o   = busy_ff;
   assign done_o   = done_ff;
   assign result_o = r_ff;
endmodule
`default_nettype wire

// ----- rtl/mlsr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_fifo
// Short queue of closed shares between the digit folder and the solver.
// ---------------------------------------------------------------------------
module mlsr_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = mlsr_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_i,
   input  wire logic [DATA_W-1:0] data_i,
   output      logic              full_o,
   input  wire logic              pop_i,
   output      logic              valid_o,
   output      logic [DATA_W-1:0] data_o
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push_i) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (pop_i) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (push_i && !pop_i) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop_i && !push_i) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_i) begin
         mem_ff[wp_ff] <= data_i;
      end
   end

   assign full_o  = (cnt_ff == CW'(DEPTH));
   assign valid_o = (cnt_ff != '0);
   assign data_o  = mem_ff[rp_ff];
endmodule
`default_nettype wire

// ----- rtl/mlsr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_front
// Folds share digits into field values and queues each closed share.
// ---------------------------------------------------------------------------
module mlsr_front #(
   parameter int MAX_SHARES = mlsr_pkg::MAX_SHARES_DEF,
   parameter int CNT_W      = $clog2(MAX_SHARES + 1),
   parameter int IDX_W      = $clog2(MAX_SHARES),
   parameter int ENT_W      = 2 + IDX_W + CNT_W + mlsr_pkg::X_W + mlsr_pkg::DATA_W
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   mlsr_req_if.sink                        req_chan,
   input  wire logic [mlsr_pkg::CSR_W-1:0] shares_used_i,
   input  wire logic                       full_i,
   output      logic                       push_o,
   output      logic [ENT_W-1:0]           entry_o
);
   localparam int LW = (CNT_W > mlsr_pkg::CSR_W) ? CNT_W : mlsr_pkg::CSR_W;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type               state_ff, state_in;
   logic [mlsr_pkg::X_W-1:0]      x_ff, x_in;
   logic [mlsr_pkg::DIGIT_W-1:0]  digit_ff, digit_in;
   logic                          vlast_ff, vlast_in, slast_ff, slast_in;
   logic [mlsr_pkg::DATA_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          mm_start, mm_busy, mm_done;
   logic [mlsr_pkg::DATA_W-1:0]   mm_res;
   logic [LW-1:0]                 su, lim, cnt_ext, n_ext;
   logic                          store;

   mlsr_modmul #(.OPB_W(mlsr_pkg::RADIX_W)) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start_i  (mm_start),
      .opa_i    (acc_ff),
      .opb_i    (req_chan.radix),
      .busy_o   (mm_busy),
      .done_o   (mm_done),
      .result_o (mm_res)
   );

   // A zero threshold acts as one; a threshold beyond the store is clipped.
   always_comb begin
      su      = LW'(shares_used_i);
      cnt_ext = LW'(count_ff);
      if (su == '0) begin
         lim = LW'(1);
      end else if (su > LW'(MAX_SHARES)) begin
         lim = LW'(MAX_SHARES);
      end else begin
         lim = su;
      end
      store = (cnt_ext < lim);
      n_ext = cnt_ext + LW'(store);
      if (n_ext > lim) begin
         n_ext = lim;
      end
   end

   assign req_chan.ready = (state_ff == F_IDLE) && !mm_busy;
   assign mm_start       = req_chan.valid && req_chan.ready;
   assign entry_o        = {store, slast_ff, count_ff[IDX_W-1:0], n_ext[CNT_W-1:0],
                            x_ff, acc_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      digit_in = digit_ff;
      vlast_in = vlast_ff;
      slast_in = slast_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      push_o   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (mm_start) begin
               x_in     = req_chan.share_x;
               digit_in = req_chan.digit;
               vlast_in = req_chan.value_last;
               slast_in = req_chan.set_last;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            if (mm_done) begin
               acc_in   = mlsr_pkg::mod_add(mm_res,
                             mlsr_pkg::DATA_W'(digit_ff));
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!(vlast_ff || slast_ff)) begin
               state_in = F_IDLE;
            end else if (!full_i) begin
               push_o   = 1'b1;
               acc_in   = '0;
               count_in = slast_ff ? '0 : count_ff + CNT_W'(store);
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
      x_ff     <= x_in;
      digit_ff <= digit_in;
      vlast_ff <= vlast_in;
      slast_ff <= slast_in;
   end
endmodule
`default_nettype wire

// ----- rtl/mlsr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mlsr_back
// Stores points and interpolates them at zero when a set closes.
// ---------------------------------------------------------------------------
module mlsr_back #(
   parameter int MAX_SHARES = mlsr_pkg::MAX_SHARES_DEF,
   parameter int CNT_W      = $clog2(MAX_SHARES + 1),
   parameter int IDX_W      = $clog2(MAX_SHARES),
   parameter int ENT_W      = 2 + IDX_W + CNT_W + mlsr_pkg::X_W + mlsr_pkg::DATA_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             valid_i,
   input  wire logic [ENT_W-1:0] entry_i,
   output      logic             pop_o,
   mlsr_rsp_if.source            rsp_chan
);
   localparam int DW = mlsr_pkg::DATA_W;
   localparam int XW = mlsr_pkg::X_W;
   localparam int PT_W = XW + DW;

   typedef enum logic [11:0] {
      B_IDLE = 12'b000000000001,
      B_RDI  = 12'b000000000010,
      B_LDI  = 12'b000000000100,
      B_RDJ  = 12'b000000001000,
      B_NUM  = 12'b000000010000,
      B_NUMW = 12'b000000100000,
      B_DENW = 12'b000001000000,
      B_SQ   = 12'b000010000000,
      B_SQW  = 12'b000100000000,
      B_MULW = 12'b001000000000,
      B_FINW = 12'b010000000000,
      B_EMIT = 12'b100000000000
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [PT_W-1:0]     mem_ff [MAX_SHARES];
   logic [PT_W-1:0]     rd_ff;
   logic [IDX_W-1:0]    ra;
   logic                we;
   logic [CNT_W-1:0]    i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [XW-1:0]       xi_ff, xi_in, xj_ff, xj_in;
   logic [DW-1:0]       num_ff, num_in, den_ff, den_in, pw_ff, pw_in, sum_ff, sum_in;
   logic [4:0]          e_ff, e_in;
   logic                out_valid_ff, out_valid_in;
   logic [DW-1:0]       out_ff, out_in;

   logic                mm_start, mm_busy, mm_done;
   logic [DW-1:0]       mm_a, mm_b, mm_res;
   logic [DW-1:0]       neg_xj, diff_x;

   logic                ent_store, ent_last;
   logic [IDX_W-1:0]    ent_idx;
   logic [CNT_W-1:0]    ent_n;
   logic [PT_W-1:0]     ent_pt;

   assign {ent_store, ent_last, ent_idx, ent_n, ent_pt} = entry_i;

   mlsr_modmul #(.OPB_W(DW)) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start_i  (mm_start),
      .opa_i    (mm_a),
      .opb_i    (mm_b),
      .busy_o   (mm_busy),
      .done_o   (mm_done),
      .result_o (mm_res)
   );

   // Numerator factor is -x_j and denominator factor x_i - x_j, both mod P.
   always_comb begin
      neg_xj = (rd_ff[PT_W-1:DW] == '0) ? '0
             : mlsr_pkg::PRIME - DW'(rd_ff[PT_W-1:DW]);
      if (xi_ff >= xj_ff) begin
         diff_x = DW'(xi_ff - xj_ff);
      end else begin
         diff_x = mlsr_pkg::PRIME - DW'(xj_ff - xi_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      xi_in        = xi_ff;
      xj_in        = xj_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      pw_in        = pw_ff;
      sum_in       = sum_ff;
      e_in         = e_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      mm_start     = 1'b0;
      mm_a         = '0;
      mm_b         = '0;
      pop_o        = 1'b0;
      we           = 1'b0;
      ra           = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (valid_i) begin
               pop_o = 1'b1;
               we    = ent_store;
               if (ent_last) begin
                  n_in     = ent_n;
                  i_in     = '0;
                  sum_in   = '0;
                  state_in = B_RDI;
               end
            end
         end
         B_RDI: begin
            if (i_ff == n_ff) begin
               state_in = B_EMIT;
            end else begin
               ra       = i_ff[IDX_W-1:0];
               state_in = B_LDI;
            end
         end
         B_LDI: begin
            xi_in    = rd_ff[PT_W-1:DW];
            num_in   = rd_ff[DW-1:0];
            den_in   = DW'(1);
            j_in     = '0;
            state_in = B_RDJ;
         end
         B_RDJ: begin
            if (j_ff == n_ff) begin
               pw_in    = DW'(1);
               e_in     = 5'(DW - 1);
               state_in = B_SQ;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               ra       = j_ff[IDX_W-1:0];
               state_in = B_NUM;
            end
         end
         B_NUM: begin
            xj_in    = rd_ff[PT_W-1:DW];
            mm_start = 1'b1;
            mm_a     = num_ff;
            mm_b     = neg_xj;
            state_in = B_NUMW;
         end
         B_NUMW: begin
            if (mm_done) begin
               num_in   = mm_res;
               mm_start = 1'b1;
               mm_a     = den_ff;
               mm_b     = diff_x;
               state_in = B_DENW;
            end
         end
         B_DENW: begin
            if (mm_done) begin
               den_in   = mm_res;
               j_in     = j_ff + CNT_W'(1);
               state_in = B_RDJ;
            end
         end
         B_SQ: begin
            mm_start = 1'b1;
            mm_a     = pw_ff;
            mm_b     = pw_ff;
            state_in = B_SQW;
         end
         B_SQW: begin
            if (mm_done) begin
               pw_in    = mm_res;
               mm_start = 1'b1;
               if (mlsr_pkg::PRIME_M2[e_ff]) begin
                  mm_a     = mm_res;
                  mm_b     = den_ff;
                  state_in = B_MULW;
               end else if (e_ff == '0) begin
                  mm_a     = num_ff;
                  mm_b     = mm_res;
                  state_in = B_FINW;
               end else begin
                  mm_start = 1'b0;
                  e_in     = e_ff - 5'd1;
                  state_in = B_SQ;
               end
            end
         end
         B_MULW: begin
            if (mm_done) begin
               pw_in = mm_res;
               if (e_ff == '0) begin
                  mm_start = 1'b1;
                  mm_a     = num_ff;
                  mm_b     = mm_res;
                  state_in = B_FINW;
               end else begin
                  e_in     = e_ff - 5'd1;
                  state_in = B_SQ;
               end
            end
         end
         B_FINW: begin
            if (mm_done) begin
               sum_in   = mlsr_pkg::mod_add(sum_ff, mm_res);
               i_in     = i_ff + CNT_W'(1);
               state_in = B_RDI;
            end
         end
         B_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_in       = sum_ff;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[ent_idx] <= ent_pt;
      end
      rd_ff <= mem_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
      xi_ff  <= xi_in;
      xj_ff  <= xj_in;
      num_ff <= num_in;
      den_ff <= den_in;
      pw_ff  <= pw_in;
      sum_ff <= sum_in;
      e_ff   <= e_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.secret = out_ff;
endmodule
`default_nettype wire

// ----- rtl/modular_lagrange_secret_recovery_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each digit is accepted, passed through the bit-serial radix multiplier, then the added digit
// is reduced and a closed share is handed to the queue.
// A closed set costs per point n-1 numerator/denominator products and one inversion by
// exponentiation, all on the shared 30-bit serial multiplier.
// The secret sits in an output register; digits of the next set are folded meanwhile.
// Synchronous reset clears control state and sets the threshold to one; point stores need none.
// ---------------------------------------------------------------------------
// modular_lagrange_secret_recovery_top
// Shamir secret recovery over the field of order 1000000007.
// ---------------------------------------------------------------------------
module modular_lagrange_secret_recovery_top #(
   parameter int MAX_SHARES = mlsr_pkg::MAX_SHARES_DEF,
   parameter int FIFO_DEPTH = mlsr_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mlsr_req_if.sink   req_chan,
   mlsr_rsp_if.source rsp_chan,
   mlsr_csr_if.sink   csr_chan
);
   localparam int CNT_W = $clog2(MAX_SHARES + 1);
   localparam int IDX_W = $clog2(MAX_SHARES);
   localparam int ENT_W = 2 + IDX_W + CNT_W + mlsr_pkg::X_W + mlsr_pkg::DATA_W;

   logic [mlsr_pkg::CSR_W-1:0] shares_used_ff, shares_used_in;
   logic                       push, full, pop, q_valid;
   logic [ENT_W-1:0]           push_data, pop_data;

   assign csr_chan.ready = 1'b1;
   assign shares_used_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data
                                                              : shares_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shares_used_ff <= mlsr_pkg::CSR_W'(1);
      end else begin
         shares_used_ff <= shares_used_in;
      end
   end

   mlsr_front #(
      .MAX_SHARES (MAX_SHARES),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .ENT_W      (ENT_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .shares_used_i (shares_used_ff),
      .full_i        (full),
      .push_o        (push),
      .entry_o       (push_data)
   );

   mlsr_fifo #(
      .DATA_W (ENT_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (push_data),
      .full_o  (full),
      .pop_i   (pop),
      .valid_o (q_valid),
      .data_o  (pop_data)
   );

   mlsr_back #(
      .MAX_SHARES (MAX_SHARES),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .ENT_W      (ENT_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (q_valid),
      .entry_i  (pop_data),
      .pop_o    (pop),
      .rsp_chan (rsp_chan)
   );

   a_secret_in_field: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.secret < mlsr_pkg::PRIME))
      else $error("secret not reduced below the prime");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("share queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !q_valid))
      else $error("share queue read while empty");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result offered straight after reset");
endmodule
`default_nettype wire
